@@ rtl/tidp_pkg.sv @@
// ----------------------------------------------------------------------------
// tidp_pkg
// Types, constants and byte-order helpers shared by the directory parser.
// ----------------------------------------------------------------------------
package tidp_pkg;

    // field lengths in bytes
    localparam int ENTRY_LEN  = 12;
    localparam int OFFSET_LEN = 4;
    localparam int COUNT_LEN  = 2;
    localparam int NEXT_LEN   = 4;

    localparam int IDX_W = 4;

    // last byte index of each gathered field
    localparam logic [IDX_W-1:0] IDX_OFFSET_LAST = IDX_W'(OFFSET_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_COUNT_LAST  = IDX_W'(COUNT_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_ENTRY_LAST  = IDX_W'(ENTRY_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_NEXT_LAST   = IDX_W'(NEXT_LEN - 1);

    // file positions
    localparam logic [31:0] FIRST_POS  = 32'd4;
    localparam logic [31:0] MIN_OFFSET = 32'd8;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIM    = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_BACKWARD  = 2'd3;

    // entry field types
    localparam logic [15:0] TYPE_BYTE   = 16'd1;
    localparam logic [15:0] TYPE_SHORT  = 16'd3;
    localparam logic [15:0] TYPE_LONG   = 16'd4;
    localparam logic [15:0] TYPE_SBYTE  = 16'd6;
    localparam logic [15:0] TYPE_SSHORT = 16'd8;
    localparam logic [15:0] TYPE_SLONG  = 16'd9;

    // dimension tags
    localparam logic [15:0] TAG_WIDTH       = 16'h0100;
    localparam logic [15:0] TAG_HEIGHT      = 16'h0101;
    localparam logic [15:0] TAG_EXIF_WIDTH  = 16'hA002;
    localparam logic [15:0] TAG_EXIF_HEIGHT = 16'hA003;

    typedef enum logic [2:0] {
        PH_OFFSET = 3'd0,
        PH_SKIP   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_ENTRY  = 3'd3,
        PH_NEXT   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef logic [ENTRY_LEN-1:0][7:0] entry_bytes_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } out_item_t;

    typedef struct packed {
        logic        width_hit;
        logic        height_hit;
        logic [31:0] value;
    } entry_info_t;

    // 16-bit value from two bytes in file order
    function automatic logic [15:0] rd16(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic be);
        rd16 = be ? {b0, b1} : {b1, b0};
    endfunction

    // 32-bit value from four bytes in file order
    function automatic logic [31:0] rd32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic be);
        rd32 = be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

endpackage

@@ rtl/tiff_ifd_dimension_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tiff_ifd_dimension_parser_unit
// Byte-stream parser for the first image directory of a TIFF file; reports
// the stored width and height with a status, or an early status on bad input.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | item
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | one file byte, end-of-stream
//  out     | out_valid, out_ready, out_data | status, width, height
//  cfg     | cfg_valid, cfg_ready, cfg_data | byte order (1 = big-endian)
//
//  One byte is accepted per cycle; its result, if any, is in the output
//  register on the next cycle. The limit is the single parser state update.
//  in_ready drops only while a result waits and out_ready is low.
//  Reset clears the parser to file offset 4, little-endian order.
//  End of stream rearms the parser; the byte order register is kept.
//
module tiff_ifd_dimension_parser_unit
    import tidp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    phase_t           phase_reg, phase_next, phase_adv;
    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      dir_off_reg, dir_off_next;
    logic [15:0]      entries_left_reg, entries_left_next;
    entry_bytes_t     ebytes_reg, ebytes_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      width_reg, width_next, width_upd;
    logic [31:0]      height_reg, height_next, height_upd;
    logic             big_endian_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg, out_data_next;

    logic             accept;
    logic             eos;
    entry_bytes_t     gather;
    logic [31:0]      offset_val;
    logic [15:0]      count_val;
    logic [15:0]      entries_dec;
    logic             offset_done, count_done, entry_done, next_done, skip_hit;
    logic             emit;
    logic             truncated;
    entry_info_t      info;

    assign accept    = in_valid && in_ready;
    assign eos       = in_data.end_of_stream;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // current byte merged into the gathered bytes
    always_comb
    begin
        for (int i = 0; i < ENTRY_LEN; i++)
        begin
            gather[i] = (idx_reg == IDX_W'(i)) ? in_data.data_byte : ebytes_reg[i];
        end
    end

    assign offset_val  = rd32(gather[0], gather[1], gather[2], gather[3], big_endian_reg);
    assign count_val   = rd16(gather[0], gather[1], big_endian_reg);
    assign entries_dec = entries_left_reg - 16'd1;

    // field completion flags
    assign offset_done = (phase_reg == PH_OFFSET) && (idx_reg == IDX_OFFSET_LAST);
    assign count_done  = (phase_reg == PH_COUNT) && (idx_reg == IDX_COUNT_LAST);
    assign entry_done  = (phase_reg == PH_ENTRY) && (idx_reg == IDX_ENTRY_LAST);
    assign next_done   = (phase_reg == PH_NEXT) && (idx_reg == IDX_NEXT_LAST);
    assign skip_hit    = (phase_reg == PH_SKIP) && ((pos_reg + 32'd1) == dir_off_reg);

    tidp_entry_decode u_entry_decode (
        .entry      (gather),
        .big_endian (big_endian_reg),
        .info       (info)
    );

    // next phase
    always_comb
    begin
        phase_adv = phase_reg;
        unique case (phase_reg)
            PH_OFFSET:
            begin
                if (offset_done)
                begin
                    if (offset_val < MIN_OFFSET)
                        phase_adv = PH_DONE;
                    else if (offset_val == MIN_OFFSET)
                        phase_adv = PH_COUNT;
                    else
                        phase_adv = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (skip_hit)
                    phase_adv = PH_COUNT;
            end
            PH_COUNT:
            begin
                if (count_done)
                    phase_adv = (count_val != 16'd0) ? PH_ENTRY : PH_NEXT;
            end
            PH_ENTRY:
            begin
                if (entry_done && entries_dec == 16'd0)
                    phase_adv = PH_NEXT;
            end
            PH_NEXT:
            begin
                if (next_done)
                    phase_adv = PH_DONE;
            end
            PH_DONE:
            begin
                phase_adv = PH_DONE;
            end
            default:
            begin
                phase_adv = phase_reg;
            end
        endcase

        phase_next = phase_reg;
        if (accept)
            phase_next = eos ? PH_OFFSET : phase_adv;
    end

    // datapath updates and result
    always_comb
    begin
        pos_next          = pos_reg;
        dir_off_next      = dir_off_reg;
        entries_left_next = entries_left_reg;
        ebytes_next       = ebytes_reg;
        idx_next          = idx_reg;
        width_upd         = width_reg;
        height_upd        = height_reg;

        if (entry_done && info.width_hit)
            width_upd = info.value;
        if (entry_done && info.height_hit)
            height_upd = info.value;

        width_next  = width_reg;
        height_next = height_reg;

        emit = (offset_done && offset_val < MIN_OFFSET) || next_done;
        truncated = eos && !emit &&
                    (phase_adv == PH_OFFSET || phase_adv == PH_SKIP ||
                     phase_adv == PH_COUNT || phase_adv == PH_ENTRY ||
                     phase_adv == PH_NEXT);

        out_data_next.image_width  = width_upd;
        out_data_next.image_height = height_upd;
        if (truncated)
            out_data_next.status = ST_TRUNCATED;
        else if (offset_done)
            out_data_next.status = ST_BACKWARD;
        else if (width_upd != 32'd0 && height_upd != 32'd0)
            out_data_next.status = ST_OK;
        else
            out_data_next.status = ST_NO_DIM;

        if (accept)
        begin
            pos_next    = pos_reg + 32'd1;
            width_next  = width_upd;
            height_next = height_upd;

            if (phase_reg == PH_OFFSET || phase_reg == PH_COUNT || phase_reg == PH_ENTRY)
                ebytes_next = gather;

            if (phase_reg == PH_OFFSET || phase_reg == PH_COUNT ||
                phase_reg == PH_ENTRY || phase_reg == PH_NEXT)
            begin
                if (offset_done || count_done || entry_done || next_done)
                    idx_next = '0;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end

            if (offset_done)
                dir_off_next = offset_val;
            if (count_done)
                entries_left_next = count_val;
            if (entry_done)
                entries_left_next = entries_dec;

            // rearm for the next file
            if (eos)
            begin
                pos_next          = FIRST_POS;
                dir_off_next      = '0;
                entries_left_next = '0;
                idx_next          = '0;
                width_next        = '0;
                height_next       = '0;
            end
        end
    end

    // parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OFFSET;
            pos_reg          <= FIRST_POS;
            dir_off_reg      <= '0;
            entries_left_reg <= '0;
            idx_reg          <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            dir_off_reg      <= dir_off_next;
            entries_left_reg <= entries_left_next;
            idx_reg          <= idx_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
        end
    end

    // gathered field bytes
    always_ff @(posedge clk)
    begin
        ebytes_reg <= ebytes_next;
    end

    // byte order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            big_endian_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            big_endian_reg <= cfg_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && (emit || truncated))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (emit || truncated))
            out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/tidp_entry_decode.sv @@
// ----------------------------------------------------------------------------
// tidp_entry_decode
// Decodes one 12-byte directory entry into a dimension hit and its value.
// ----------------------------------------------------------------------------
module tidp_entry_decode
    import tidp_pkg::*;
(
    input  entry_bytes_t entry,
    input  logic         big_endian,
    output entry_info_t  info
);

    logic [15:0] tag;
    logic [15:0] type_code;
    logic [15:0] short_val;
    logic [31:0] value;
    logic        known;

    assign tag       = rd16(entry[0], entry[1], big_endian);
    assign type_code = rd16(entry[2], entry[3], big_endian);
    assign short_val = rd16(entry[8], entry[9], big_endian);

    // value extension by field type
    always_comb
    begin
        value = '0;
        known = 1'b1;
        case (type_code) inside
            TYPE_BYTE, TYPE_SBYTE:
            begin
                value = {24'd0, entry[8]};
            end
            TYPE_SHORT:
            begin
                value = {16'd0, short_val};
            end
            TYPE_SSHORT:
            begin
                value = {{16{short_val[15]}}, short_val};
            end
            TYPE_LONG, TYPE_SLONG:
            begin
                value = rd32(entry[8], entry[9], entry[10], entry[11], big_endian);
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // tag match
    assign info.width_hit  = known && (tag == TAG_WIDTH || tag == TAG_EXIF_WIDTH);
    assign info.height_hit = known && (tag == TAG_HEIGHT || tag == TAG_EXIF_HEIGHT);
    assign info.value      = value;

endmodule

@@ tb/tb_tiff_ifd_dimension_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiff_ifd_dimension_parser_unit
// Streams short TIFF files into the directory parser byte by byte, in both
// byte orders, and compares every status, width and height result against a
// cycle-free model of the parser kept inside the bench.
// ----------------------------------------------------------------------------
module tb_tiff_ifd_dimension_parser_unit;
    import tidp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 1700;
    localparam int CFG_PHASES   = 6;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    tiff_ifd_dimension_parser_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock, 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shared bench state
    out_item_t   pending_dims[$];
    logic [7:0]  file_q[$];
    logic        file_be;
    int          idle_pct;
    int          err_cnt;
    int unsigned cycle_cnt;
    int          bytes_sent;
    logic        hold_trig;
    logic        hold_seen;
    int          hold_left;

    // parser model state
    logic        mdl_be;
    phase_t      mdl_phase;
    logic [31:0] mdl_pos;
    logic [31:0] mdl_dir_off;
    logic [15:0] mdl_left;
    logic [7:0]  mdl_buf [ENTRY_LEN];
    logic [3:0]  mdl_idx;
    logic [31:0] mdl_width;
    logic [31:0] mdl_height;

    // field assembly in the configured byte order
    function automatic logic [15:0] file_u16(input logic [7:0] b0, input logic [7:0] b1);
        file_u16 = mdl_be ? {b0, b1} : {b1, b0};
    endfunction

    function automatic logic [31:0] file_u32(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
        file_u32 = mdl_be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    // back to file offset 4, byte order untouched
    task automatic rearm_parser();
        mdl_phase   = PH_OFFSET;
        mdl_pos     = FIRST_POS;
        mdl_dir_off = '0;
        mdl_left    = '0;
        for (int i = 0; i < ENTRY_LEN; i++)
            mdl_buf[i] = '0;
        mdl_idx     = '0;
        mdl_width   = '0;
        mdl_height  = '0;
    endtask

    // pick up a width or height from a completed 12-byte entry
    task automatic decode_entry();
        logic [15:0] tag;
        logic [15:0] ftype;
        logic [15:0] v16;
        logic [31:0] v;
        logic        known;
        tag   = file_u16(mdl_buf[0], mdl_buf[1]);
        ftype = file_u16(mdl_buf[2], mdl_buf[3]);
        v16   = file_u16(mdl_buf[8], mdl_buf[9]);
        known = 1'b1;
        v     = '0;
        case (ftype)
            TYPE_BYTE, TYPE_SBYTE: v = {24'd0, mdl_buf[8]};
            TYPE_SHORT:            v = {16'd0, v16};
            TYPE_SSHORT:           v = {{16{v16[15]}}, v16};
            TYPE_LONG, TYPE_SLONG:
                v = file_u32(mdl_buf[8], mdl_buf[9], mdl_buf[10], mdl_buf[11]);
            default:               known = 1'b0;
        endcase
        if (known)
        begin
            if (tag == TAG_WIDTH || tag == TAG_EXIF_WIDTH)
                mdl_width = v;
            else if (tag == TAG_HEIGHT || tag == TAG_EXIF_HEIGHT)
                mdl_height = v;
        end
    endtask

    // advance the model by one file byte, queue the result it causes
    task automatic predict_dimensions(input in_item_t it);
        logic      emit;
        logic [1:0] st;
        out_item_t r;
        emit = 1'b0;
        st   = ST_OK;
        if (mdl_idx >= ENTRY_LEN)
            mdl_idx = '0;
        case (mdl_phase)
            PH_OFFSET:
            begin
                mdl_buf[mdl_idx] = it.data_byte;
                mdl_idx = mdl_idx + 1'b1;
                if (mdl_idx == OFFSET_LEN)
                begin
                    mdl_idx = '0;
                    mdl_dir_off = file_u32(mdl_buf[0], mdl_buf[1], mdl_buf[2], mdl_buf[3]);
                    if (mdl_dir_off < MIN_OFFSET)
                    begin
                        emit = 1'b1;
                        st = ST_BACKWARD;
                        mdl_phase = PH_DONE;
                    end
                    else if (mdl_dir_off == MIN_OFFSET)
                        mdl_phase = PH_COUNT;
                    else
                        mdl_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (mdl_pos + 32'd1 == mdl_dir_off)
                    mdl_phase = PH_COUNT;
            end
            PH_COUNT:
            begin
                mdl_buf[mdl_idx] = it.data_byte;
                mdl_idx = mdl_idx + 1'b1;
                if (mdl_idx == COUNT_LEN)
                begin
                    mdl_idx = '0;
                    mdl_left = file_u16(mdl_buf[0], mdl_buf[1]);
                    mdl_phase = (mdl_left != 0) ? PH_ENTRY : PH_NEXT;
                end
            end
            PH_ENTRY:
            begin
                mdl_buf[mdl_idx] = it.data_byte;
                mdl_idx = mdl_idx + 1'b1;
                if (mdl_idx == ENTRY_LEN)
                begin
                    mdl_idx = '0;
                    decode_entry();
                    mdl_left = mdl_left - 16'd1;
                    if (mdl_left == 0)
                        mdl_phase = PH_NEXT;
                end
            end
            PH_NEXT:
            begin
                mdl_idx = mdl_idx + 1'b1;
                if (mdl_idx == NEXT_LEN)
                begin
                    mdl_idx = '0;
                    emit = 1'b1;
                    st = (mdl_width != 0 && mdl_height != 0) ? ST_OK : ST_NO_DIM;
                    mdl_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        mdl_pos = mdl_pos + 32'd1;

        // stream cut short before any result
        if (it.end_of_stream && !emit && mdl_phase != PH_DONE)
        begin
            emit = 1'b1;
            st = ST_TRUNCATED;
        end

        if (emit)
        begin
            r.status       = st;
            r.image_width  = mdl_width;
            r.image_height = mdl_height;
            pending_dims.push_back(r);
        end
        if (it.end_of_stream)
            rearm_parser();
    endtask

    // track accepted bytes and register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            mdl_be = cfg_data;
        if (rst_n && in_valid && in_ready)
            predict_dimensions(in_data);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dims.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, out_data);
                err_cnt++;
            end
            else
            begin
                want = pending_dims.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    err_cnt++;
                end
                if (out_data.image_width !== want.image_width)
                begin
                    $display("%0t: width mismatch expected %h actual %h",
                             $time, want.image_width, out_data.image_width);
                    err_cnt++;
                end
                if (out_data.image_height !== want.image_height)
                begin
                    $display("%0t: height mismatch expected %h actual %h",
                             $time, want.image_height, out_data.image_height);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_trig != hold_seen)
        begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one byte, return at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_stream: eos};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // whole file from file_q, end of stream on the last byte
    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    // stop sending and wait until every result is out
    task automatic settle_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dims.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_byte_order(input logic be);
        cfg_valid <= 1'b1;
        cfg_data  <= be;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        file_be = be;
    endtask

    task automatic put16(input logic [15:0] v);
        if (file_be)
        begin
            file_q.push_back(v[15:8]);
            file_q.push_back(v[7:0]);
        end
        else
        begin
            file_q.push_back(v[7:0]);
            file_q.push_back(v[15:8]);
        end
    endtask

    task automatic put32(input logic [31:0] v);
        if (file_be)
        begin
            put16(v[31:16]);
            put16(v[15:0]);
        end
        else
        begin
            put16(v[15:0]);
            put16(v[31:16]);
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0:       pick_value = 32'h0000_0000;
            1:       pick_value = 32'hFFFF_FFFF;
            2:       pick_value = 32'h0000_8000;
            3:       pick_value = 32'h8000_0000;
            default: pick_value = $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_tag();
        case ($urandom_range(4))
            0:       pick_tag = TAG_WIDTH;
            1:       pick_tag = TAG_HEIGHT;
            2:       pick_tag = TAG_EXIF_WIDTH;
            3:       pick_tag = TAG_EXIF_HEIGHT;
            default: pick_tag = 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_type();
        case ($urandom_range(7))
            0:       pick_type = TYPE_BYTE;
            1:       pick_type = TYPE_SHORT;
            2:       pick_type = TYPE_LONG;
            3:       pick_type = TYPE_SBYTE;
            4:       pick_type = TYPE_SSHORT;
            5:       pick_type = TYPE_SLONG;
            6:       pick_type = 16'($urandom_range(15));
            default: pick_type = 16'($urandom);
        endcase
    endfunction

    // random file: mostly well formed, some cut short, some backward, some noise
    task automatic build_random_file();
        int          kind;
        int          skip;
        int          cnt;
        int          cut;
        logic [15:0] ftype;
        logic [31:0] v;
        file_q.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 40))
                file_q.push_back(8'($urandom));
        end
        else if (kind < 14)
            put32($urandom_range(7));
        else
        begin
            skip = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
            put32(MIN_OFFSET + skip);
            repeat (skip)
                file_q.push_back(8'($urandom));
            cnt = ($urandom_range(19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 4);
            if ($urandom_range(29) == 0)
                put16(16'hFFFF);
            else
                put16(16'(cnt));
            repeat (cnt)
            begin
                ftype = pick_type();
                v = pick_value();
                put16(pick_tag());
                put16(ftype);
                put32($urandom);
                if (ftype == TYPE_BYTE || ftype == TYPE_SBYTE)
                begin
                    file_q.push_back(v[7:0]);
                    repeat (3) file_q.push_back(8'($urandom));
                end
                else if (ftype == TYPE_SHORT || ftype == TYPE_SSHORT)
                begin
                    put16(v[15:0]);
                    put16(16'($urandom));
                end
                else
                    put32(v);
            end
            put32($urandom);
            repeat ($urandom_range(0, 3))
                file_q.push_back(8'($urandom));
            // broken sequence: stream ends part way
            if ($urandom_range(5) == 0)
            begin
                cut = $urandom_range(1, file_q.size());
                while (file_q.size() > cut)
                    void'(file_q.pop_back());
            end
        end
    endtask

    // directed: backward, early end, offset 8, zero count, ignored tail, cut skip
    task automatic test_special_cases();
        // backward offset, end of stream on the completing byte
        file_q = '{8'h07, 8'h00, 8'h00, 8'h00};
        send_file();
        // end of stream on the very first byte
        file_q = '{8'hFF};
        send_file();
        // offset 8, zero entries, pointer, then an ignored byte
        file_q = '{8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_file();
        // far offset, cut while skipping
        file_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_file();
        settle_results();
    endtask

    // random files over several byte-order settings
    task automatic test_random_files();
        int start;
        for (int ph = 0; ph < CFG_PHASES; ph++)
        begin
            settle_results();
            write_byte_order((ph % 2) == 0);
            idle_pct <= (ph == 2) ? 0 : 19;
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_BYTES / CFG_PHASES)
            begin
                build_random_file();
                send_file();
            end
        end
        idle_pct <= 19;
        settle_results();
    endtask

    // long receiver hold-off fills the block, then the sender waits it out
    task automatic test_backpressure();
        hold_trig <= ~hold_trig;
        repeat (6)
        begin
            file_q.delete();
            put32($urandom_range(7));
            send_file();
        end
        settle_results();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        out_ready  = 1'b0;
        hold_trig  = 1'b0;
        hold_seen  = 1'b0;
        hold_left  = 0;
        idle_pct   = 19;
        err_cnt    = 0;
        cycle_cnt  = 0;
        bytes_sent = 0;
        file_be    = 1'b0;
        mdl_be     = 1'b0;
        rearm_parser();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random_files();
        test_backpressure();

        settle_results();
        if (pending_dims.size() != 0)
        begin
            $display("%0t: results missing expected %0d more actual 0",
                     $time, pending_dims.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
